// ----- design/v3a_pkg.sv -----
// v3a_pkg: shared constants, operation and status codes for the vector alu
// no dependencies
`timescale 1ns / 1ps
package v3a_pkg;
   localparam int FracBitsDefault = 16;
   localparam int WordBitsDefault = 32;

   localparam logic [3:0] FUNC_ADD   = 4'd0;
   localparam logic [3:0] FUNC_SUB   = 4'd1;
   localparam logic [3:0] FUNC_SCALE = 4'd2;
   localparam logic [3:0] FUNC_DIV   = 4'd3;
   localparam logic [3:0] FUNC_NEG   = 4'd4;
   localparam logic [3:0] FUNC_CROSS = 4'd5;
   localparam logic [3:0] FUNC_DOT   = 4'd6;
   localparam logic [3:0] FUNC_LENSQ = 4'd7;
   localparam logic [3:0] FUNC_LEN   = 4'd8;
   localparam logic [3:0] FUNC_NORM  = 4'd9;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_DZ  = 2'd1;
   localparam logic [1:0] STAT_SAT = 2'd2;
endpackage

// ----- design/v3a_mul.sv -----
// v3a_mul: registered signed multiplier, one product per cycle with enable
// depends on nothing
`timescale 1ns / 1ps
module v3a_mul #(
   parameter int WordBits = 32
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [WordBits-1:0]  a,
   input  logic signed [WordBits-1:0]  b,
   output logic signed [2*WordBits-1:0] p
);
   logic signed [2*WordBits-1:0] p_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= a * b;
      end
   end
   assign p = p_ff;
endmodule

// ----- design/v3a_sqrt.sv -----
// v3a_sqrt: pipelined floor square root, one result bit per stage
// depends on nothing
`timescale 1ns / 1ps
module v3a_sqrt #(
   parameter int InBits  = 98,
   parameter int OutBits = 49,
   parameter int TagBits = 8
) (
   input  logic               clock,
   input  logic               en,
   input  logic [InBits-1:0]  x,
   input  logic [TagBits-1:0] tag_in,
   output logic [OutBits-1:0] root,
   output logic [TagBits-1:0] tag_out
);
   localparam int RemBits = OutBits + 2;
   localparam int XBits   = 2 * OutBits;

   logic [XBits-1:0]   x_ff   [OutBits+1];
   logic [RemBits-1:0] rem_ff [OutBits+1];
   logic [OutBits-1:0] r_ff   [OutBits+1];
   logic [TagBits-1:0] tag_ff [OutBits+1];

   always_comb begin
      x_ff[0]   = XBits'(x);
      rem_ff[0] = '0;
      r_ff[0]   = '0;
      tag_ff[0] = tag_in;
   end

   for (genvar g = 0; g < OutBits; g++) begin : g_stage
      logic [RemBits-1:0] rem_sh;
      logic [RemBits-1:0] trial;
      logic [RemBits-1:0] rem_in;
      logic [OutBits-1:0] r_in;
      logic [XBits-1:0]   xs;
      always_comb begin
         xs     = x_ff[g];
         rem_sh = {rem_ff[g][RemBits-3:0], xs[XBits-1 -: 2]};
         trial  = {r_ff[g], 2'b01};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            r_in   = {r_ff[g][OutBits-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            r_in   = {r_ff[g][OutBits-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g+1]   <= {xs[XBits-3:0], 2'b00};
            rem_ff[g+1] <= rem_in;
            r_ff[g+1]   <= r_in;
            tag_ff[g+1] <= tag_ff[g];
         end
      end
   end

   assign root    = r_ff[OutBits];
   assign tag_out = tag_ff[OutBits];
endmodule

// ----- design/v3a_div.sv -----
// v3a_div: pipelined restoring divider, unsigned, one quotient bit per stage
// depends on nothing
`timescale 1ns / 1ps
module v3a_div #(
   parameter int NumBits = 48,
   parameter int DenBits = 49
) (
   input  logic               clock,
   input  logic               en,
   input  logic [NumBits-1:0] num,
   input  logic [DenBits-1:0] den,
   output logic [NumBits-1:0] quo
);
   localparam int RemBits = DenBits + 1;

   logic [NumBits-1:0] n_ff   [NumBits+1];
   logic [DenBits-1:0] d_ff   [NumBits+1];
   logic [RemBits-1:0] rem_ff [NumBits+1];
   logic [NumBits-1:0] q_ff   [NumBits+1];

   always_comb begin
      n_ff[0]   = num;
      d_ff[0]   = den;
      rem_ff[0] = '0;
      q_ff[0]   = '0;
   end

   for (genvar g = 0; g < NumBits; g++) begin : g_stage
      logic [RemBits-1:0] rem_sh;
      logic [RemBits-1:0] rem_in;
      logic               qb;
      always_comb begin
         rem_sh = {rem_ff[g][RemBits-2:0], n_ff[g][NumBits-1]};
         qb     = rem_sh >= RemBits'(d_ff[g]);
         rem_in = qb ? rem_sh - RemBits'(d_ff[g]) : rem_sh;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[g+1]   <= n_ff[g] << 1;
            d_ff[g+1]   <= d_ff[g];
            rem_ff[g+1] <= rem_in;
            q_ff[g+1]   <= {q_ff[g][NumBits-2:0], qb};
         end
      end
   end

   assign quo = q_ff[NumBits];
endmodule

// ----- design/vec3_fixed_point_alu.sv -----
// Three-component signed fixed-point vector alu.
//
// Input channel req_ (valid/ready) carries func, vectors a and b and a scalar;
// result channel rsp_ (valid/ready) carries res_x/y/z, res_scalar and status.
// One result per input item, in order.
//
// All operations take the same path from acceptance to rsp_valid (W word
// bits, F fraction bits, Q16.16 by default): a multiply stage, a sum stage,
// a square-root pipeline of W+1 stages for the length, a divisor stage,
// a divider pipeline of W+F stages for divide and normalize, then the
// output register.
// Throughput: one item per cycle while the output is not stalled.
//
// The whole pipeline advances when the last stage is empty or its item is
// taken; when rsp_ready is low and the output holds an item, all stages hold
// and req_ready drops. Nothing is lost or repeated.
//
// Reset (synchronous, active high) clears all valid bits; the block is ready
// in the cycle after reset falls.
`timescale 1ns / 1ps
module vec3_fixed_point_alu #(
   parameter int FRAC_BITS = v3a_pkg::FracBitsDefault,
   parameter int WORD_BITS = v3a_pkg::WordBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [3:0]                  req_func,
   input  logic signed [WORD_BITS-1:0] req_a_x,
   input  logic signed [WORD_BITS-1:0] req_a_y,
   input  logic signed [WORD_BITS-1:0] req_a_z,
   input  logic signed [WORD_BITS-1:0] req_b_x,
   input  logic signed [WORD_BITS-1:0] req_b_y,
   input  logic signed [WORD_BITS-1:0] req_b_z,
   input  logic signed [WORD_BITS-1:0] req_scalar_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_res_x,
   output logic signed [WORD_BITS-1:0] rsp_res_y,
   output logic signed [WORD_BITS-1:0] rsp_res_z,
   output logic signed [WORD_BITS-1:0] rsp_res_scalar,
   output logic [1:0]                  rsp_status
);
   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;          // product width
   localparam int SW  = PW + 2;         // sum of three products
   localparam int RB  = W + 1;          // root bits (floor root of sum of squares)
   localparam int SQI = 2 * RB;         // sqrt input width
   localparam int NB  = W + F;          // dividend bits (|a| << F)
   localparam int DB  = RB;             // divisor bits
   localparam int LAT = RB + NB + 4;    // stage count incl. mul, sum, prep, out
   localparam int TB  = 4 + 3 * W + W + 1; // tag width through sqrt

   logic adv;
   logic [LAT-1:0] vld_ff;

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: products
   logic signed [W-1:0] ma [9];
   logic signed [W-1:0] mb [9];
   logic signed [PW-1:0] pr [9];
   always_comb begin
      ma[0] = req_a_x; ma[1] = req_a_y; ma[2] = req_a_z;
      mb[0] = (req_func == v3a_pkg::FUNC_DOT) ? req_b_x :
              (req_func == v3a_pkg::FUNC_SCALE) ? req_scalar_in : req_a_x;
      mb[1] = (req_func == v3a_pkg::FUNC_DOT) ? req_b_y :
              (req_func == v3a_pkg::FUNC_SCALE) ? req_scalar_in : req_a_y;
      mb[2] = (req_func == v3a_pkg::FUNC_DOT) ? req_b_z :
              (req_func == v3a_pkg::FUNC_SCALE) ? req_scalar_in : req_a_z;
      // cross terms: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
      ma[3] = req_a_y; mb[3] = req_b_z;
      ma[4] = req_a_z; mb[4] = req_b_y;
      ma[5] = req_a_z; mb[5] = req_b_x;
      ma[6] = req_a_x; mb[6] = req_b_z;
      ma[7] = req_a_x; mb[7] = req_b_y;
      ma[8] = req_a_y; mb[8] = req_b_x;
   end
   for (genvar g = 0; g < 9; g++) begin : g_mul
      v3a_mul #(.WordBits(W)) u_mul (
         .clock(clock), .en(adv), .a(ma[g]), .b(mb[g]), .p(pr[g])
      );
   end

   logic [3:0]          f1_ff;
   logic signed [W-1:0] a1_ff [3];
   logic signed [W-1:0] b1_ff [3];
   logic signed [W-1:0] s1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= req_func;
         a1_ff[0] <= req_a_x; a1_ff[1] <= req_a_y; a1_ff[2] <= req_a_z;
         b1_ff[0] <= req_b_x; b1_ff[1] <= req_b_y; b1_ff[2] <= req_b_z;
         s1_ff <= req_scalar_in;
      end
   end

   // stage 2: sums, shifts, saturation of simple results
   function automatic logic signed [W-1:0] sat_fn(input logic signed [SW-1:0] v,
                                                  output logic ov);
      logic signed [SW-1:0] mx;
      logic signed [SW-1:0] mn;
      mx = SW'({1'b0, {(W-1){1'b1}}});
      mn = -mx - SW'(1);
      ov = 1'b0;
      if (v > mx) begin
         ov = 1'b1;
         return mx[W-1:0];
      end else if (v < mn) begin
         ov = 1'b1;
         return mn[W-1:0];
      end
      return v[W-1:0];
   endfunction

   logic signed [SW-1:0] sum_p;
   logic signed [SW-1:0] e_v [3];
   logic signed [SW-1:0] e_s;
   logic signed [W-1:0]  v2_in [3];
   logic signed [W-1:0]  sc2_in;
   logic                 ov2_in;
   logic                 ov_t [4];
   logic [SQI-1:0]       sq_in;
   always_comb begin
      sum_p = SW'(pr[0]) + SW'(pr[1]) + SW'(pr[2]);
      sq_in = SQI'(sum_p);
      for (int i = 0; i < 3; i++) begin
         e_v[i] = '0;
      end
      e_s = '0;
      unique case (f1_ff)
         v3a_pkg::FUNC_ADD: begin
            for (int i = 0; i < 3; i++) e_v[i] = SW'(a1_ff[i]) + SW'(b1_ff[i]);
         end
         v3a_pkg::FUNC_SUB: begin
            for (int i = 0; i < 3; i++) e_v[i] = SW'(a1_ff[i]) - SW'(b1_ff[i]);
         end
         v3a_pkg::FUNC_NEG: begin
            for (int i = 0; i < 3; i++) e_v[i] = -SW'(a1_ff[i]);
         end
         v3a_pkg::FUNC_SCALE: begin
            e_v[0] = SW'(pr[0]) >>> F;
            e_v[1] = SW'(pr[1]) >>> F;
            e_v[2] = SW'(pr[2]) >>> F;
         end
         v3a_pkg::FUNC_CROSS: begin
            e_v[0] = (SW'(pr[3]) - SW'(pr[4])) >>> F;
            e_v[1] = (SW'(pr[5]) - SW'(pr[6])) >>> F;
            e_v[2] = (SW'(pr[7]) - SW'(pr[8])) >>> F;
         end
         v3a_pkg::FUNC_DOT, v3a_pkg::FUNC_LENSQ: begin
            e_s = sum_p >>> F;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 3; i++) v2_in[i] = sat_fn(e_v[i], ov_t[i]);
      sc2_in = sat_fn(e_s, ov_t[3]);
      ov2_in = ov_t[0] | ov_t[1] | ov_t[2] | ov_t[3];
   end

   // tag through sqrt: func, a, partial results packed
   logic [TB-1:0] tag_in;
   logic [TB-1:0] tag_out;
   logic [3*W-1:0] v2_pack;
   assign v2_pack = {v2_in[2], v2_in[1], v2_in[0]};
   // vector results reuse the a slot when the op does not need a
   assign tag_in = {f1_ff,
                    (f1_ff == v3a_pkg::FUNC_DIV || f1_ff == v3a_pkg::FUNC_NORM) ?
                       {a1_ff[2], a1_ff[1], a1_ff[0]} : v2_pack,
                    (f1_ff == v3a_pkg::FUNC_DIV) ? s1_ff : sc2_in,
                    ov2_in};

   logic [SQI-1:0] sq_ff;
   logic [TB-1:0]  t2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
         t2_ff <= tag_in;
      end
   end

   logic [RB-1:0] root;
   v3a_sqrt #(.InBits(SQI), .OutBits(RB), .TagBits(TB)) u_sqrt (
      .clock(clock), .en(adv), .x(sq_ff), .tag_in(t2_ff),
      .root(root), .tag_out(tag_out)
   );

   // stage after sqrt: choose divisor, magnitudes
   logic [3:0]          f3;
   logic [3*W-1:0]      av3;
   logic signed [W-1:0] sw3;
   logic                ov3;
   assign {f3, av3, sw3, ov3} = tag_out;

   logic [NB-1:0] num_in [3];
   logic [DB-1:0] den_in;
   logic          neg_in [3];
   logic          dz_in;
   logic signed [W-1:0] comp [3];
   logic [W-1:0]  smag;
   always_comb begin
      for (int i = 0; i < 3; i++) comp[i] = av3[i*W +: W];
      smag = sw3[W-1] ? W'(-sw3) : W'(sw3);
      den_in = (f3 == v3a_pkg::FUNC_DIV) ? DB'(smag) : root;
      dz_in  = (f3 == v3a_pkg::FUNC_DIV || f3 == v3a_pkg::FUNC_NORM) && den_in == '0;
      for (int i = 0; i < 3; i++) begin
         num_in[i] = NB'(comp[i][W-1] ? W'(-comp[i]) : W'(comp[i])) << F;
         neg_in[i] = comp[i][W-1] ^ ((f3 == v3a_pkg::FUNC_DIV) && sw3[W-1]);
      end
   end

   logic [NB-1:0] nm_ff [3];
   logic [DB-1:0] dn_ff;
   localparam int CB = 4 + 3 * W + W + RB + 1 + 3 + 1;
   logic [CB-1:0] c3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) nm_ff[i] <= num_in[i];
         dn_ff <= (den_in == '0) ? DB'(1) : den_in;
         c3_ff <= {f3, av3, sw3, root, ov3, neg_in[2], neg_in[1], neg_in[0], dz_in};
      end
   end

   logic [NB-1:0] quo [3];
   for (genvar g = 0; g < 3; g++) begin : g_div
      v3a_div #(.NumBits(NB), .DenBits(DB)) u_div (
         .clock(clock), .en(adv), .num(nm_ff[g]), .den(dn_ff), .quo(quo[g])
      );
   end

   // carry control alongside the divider
   logic [CB-1:0] cd_ff [NB+1];
   assign cd_ff[0] = c3_ff;
   for (genvar g = 0; g < NB; g++) begin : g_dly
      always_ff @(posedge clock) begin
         if (adv) begin
            cd_ff[g+1] <= cd_ff[g];
         end
      end
   end

   // final: sign, saturate, select
   logic [3:0]          ff;
   logic [3*W-1:0]      fav;
   logic signed [W-1:0] fsw;
   logic [RB-1:0]       froot;
   logic                fov;
   logic [2:0]          fneg;
   logic                fdz;
   assign {ff, fav, fsw, froot, fov, fneg, fdz} = cd_ff[NB];

   logic signed [W-1:0] ox_in [3];
   logic signed [W-1:0] os_in;
   logic [1:0]          ost_in;
   logic                dv_ov [3];
   logic                len_ov;
   logic signed [SW-1:0] qs;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ox_in[i] = fav[i*W +: W];
         dv_ov[i] = 1'b0;
      end
      os_in  = fsw;
      len_ov = 1'b0;
      ost_in = fov ? v3a_pkg::STAT_SAT : v3a_pkg::STAT_OK;
      qs     = '0;
      unique case (ff)
         v3a_pkg::FUNC_DIV, v3a_pkg::FUNC_NORM: begin
            os_in = '0;
            for (int i = 0; i < 3; i++) begin
               qs = fneg[i] ? -SW'(quo[i]) : SW'(quo[i]);
               ox_in[i] = fdz ? '0 : sat_fn(qs, dv_ov[i]);
            end
            if (fdz) begin
               ost_in = v3a_pkg::STAT_DZ;
            end else if (dv_ov[0] | dv_ov[1] | dv_ov[2]) begin
               ost_in = v3a_pkg::STAT_SAT;
            end else begin
               ost_in = v3a_pkg::STAT_OK;
            end
         end
         v3a_pkg::FUNC_LEN: begin
            for (int i = 0; i < 3; i++) ox_in[i] = '0;
            os_in  = sat_fn(SW'(froot), len_ov);
            ost_in = len_ov ? v3a_pkg::STAT_SAT : v3a_pkg::STAT_OK;
         end
         default: begin
         end
      endcase
   end

   logic signed [W-1:0] rx_ff, ry_ff, rz_ff, rs_ff;
   logic [1:0]          st_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff <= ox_in[0];
         ry_ff <= ox_in[1];
         rz_ff <= ox_in[2];
         rs_ff <= os_in;
         st_ff <= ost_in;
      end
   end

   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_res_x      = rx_ff;
   assign rsp_res_y      = ry_ff;
   assign rsp_res_z      = rz_ff;
   assign rsp_res_scalar = rs_ff;
   assign rsp_status     = st_ff;
endmodule

// ----- design/v3a_checker.sv -----
// v3a_checker: port-level checks for the vector alu, bound to the top level
// depends on v3a_pkg and vec3_fixed_point_alu
`timescale 1ns / 1ps
module v3a_checker #(
   parameter int WORD_BITS = v3a_pkg::WordBitsDefault
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_res_x,
   input logic [WORD_BITS-1:0] rsp_res_scalar,
   input logic [1:0]           rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_x) && $stable(rsp_status))
      else $error("result item changed while stalled");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == v3a_pkg::STAT_DZ |-> rsp_res_x == '0 && rsp_res_scalar == '0)
      else $error("divide by zero result not zero");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind vec3_fixed_point_alu v3a_checker #(.WORD_BITS(WORD_BITS)) u_v3a_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_res_x(rsp_res_x),
   .rsp_res_scalar(rsp_res_scalar), .rsp_status(rsp_status)
);
